@@ design/prls_pkg.sv @@
// Shared types and constants of the priority ready list scheduler.
// Holds field widths, action codes, controller states and the command and
// status structs that join controller and datapath. No dependencies.
package prls_pkg;

   // Field widths of the request and response items
   localparam int ACTION_W = 2;
   localparam int TASK_W   = 5;
   localparam int PRIO_W   = 4;

   // Default sizing of the ready list
   localparam int NUM_TASKS_DEF   = 32;
   localparam int PRIO_LEVELS_DEF = 16;

   // Register port
   localparam int CSR_ADDR_W    = 3;
   localparam int CSR_DATA_W    = 32;
   localparam int CSR_INDEX_BIT = 2;
   localparam logic REG_IDLE_TASK = 1'b0;

   typedef enum logic [ACTION_W-1:0] {
      ACT_INSERT   = 2'd0,
      ACT_REMOVE   = 2'd1,
      ACT_SCHEDULE = 2'd2
   } action_type;

   typedef enum logic [3:0] {
      ST_INIT,
      ST_IDLE,
      ST_INS_ANCHOR,
      ST_INS_LINK,
      ST_INS_CLOSE,
      ST_REM_LEVEL,
      ST_REM_LINK,
      ST_RESP
   } state_type;

   // Which set of table reads the datapath issues this cycle
   typedef enum logic [1:0] {
      RD_NONE,
      RD_REQ,
      RD_INS_ANCHOR,
      RD_REM_LEVEL
   } rd_cmd_type;

   // Which set of table writes the datapath performs this cycle
   typedef enum logic [2:0] {
      WR_NONE,
      WR_INIT,
      WR_INS_LINK,
      WR_INS_CLOSE,
      WR_REM_LINK
   } wr_cmd_type;

   typedef struct packed {
      logic       capture;
      rd_cmd_type rd;
      wr_cmd_type wr;
      logic       out_load;
   } prls_cmd_type;

   typedef struct packed {
      logic ins_ok;
      logic rem_ok;
      logic out_busy;
   } prls_status_type;

endpackage

@@ design/prls_if.sv @@
// Valid/ready channel interfaces for requests and responses.
// Depends on prls_pkg for the field widths.
interface prls_req_if import prls_pkg::*; ();
   logic                valid;
   logic                ready;
   logic [ACTION_W-1:0] action;
   logic [TASK_W-1:0]   task_id;
   logic [PRIO_W-1:0]   priority_req;
   logic                critical;
   logic [TASK_W-1:0]   current_task;
   logic                current_valid;

   modport source (
      output valid, action, task_id, priority_req, critical, current_task, current_valid,
      input  ready
   );
   modport sink (
      input  valid, action, task_id, priority_req, critical, current_task, current_valid,
      output ready
   );
endinterface

interface prls_rsp_if import prls_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [TASK_W-1:0] next_task;
   logic              dispatch_needed;
   logic              skipped;

   modport source (
      output valid, next_task, dispatch_needed, skipped,
      input  ready
   );
   modport sink (
      input  valid, next_task, dispatch_needed, skipped,
      output ready
   );
endinterface

@@ design/prls_ctrl.sv @@
// Sequencer of the ready list: walks each request through its table reads
// and writes. Depends on prls_pkg for states, command and status structs.
module prls_ctrl import prls_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  prls_status_type status,
   output prls_cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      req_ready    = 1'b0;
      cmd.capture  = 1'b0;
      cmd.rd       = RD_NONE;
      cmd.wr       = WR_NONE;
      cmd.out_load = 1'b0;
      case (state_ff)
         ST_INIT: begin
            // seed the idle entries of the tables
            cmd.wr   = WR_INIT;
            state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.rd    = RD_REQ;
            if (req_valid) begin
               cmd.capture = 1'b1;
               if (status.ins_ok) begin
                  state_in = ST_INS_ANCHOR;
               end else if (status.rem_ok) begin
                  state_in = ST_REM_LEVEL;
               end else begin
                  state_in = ST_RESP;
               end
            end
         end
         ST_INS_ANCHOR: begin
            cmd.rd   = RD_INS_ANCHOR;
            state_in = ST_INS_LINK;
         end
         ST_INS_LINK: begin
            cmd.wr   = WR_INS_LINK;
            state_in = ST_INS_CLOSE;
         end
         ST_INS_CLOSE: begin
            cmd.wr   = WR_INS_CLOSE;
            state_in = ST_RESP;
         end
         ST_REM_LEVEL: begin
            cmd.rd   = RD_REM_LEVEL;
            state_in = ST_REM_LINK;
         end
         ST_REM_LINK: begin
            cmd.wr   = WR_REM_LINK;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            // hold until the output register is free
            if (!status.out_busy) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ design/prls_datapath.sv @@
// Link tables, level records, occupancy bitmap, idle register and output
// register of the ready list. Depends on prls_pkg; driven by prls_ctrl.
module prls_datapath import prls_pkg::*; #(
   parameter int NUM_TASKS   = NUM_TASKS_DEF,
   parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  prls_cmd_type          cmd,
   output prls_status_type       status,
   input  logic [ACTION_W-1:0]   req_action,
   input  logic [TASK_W-1:0]     req_task_id,
   input  logic [PRIO_W-1:0]     req_priority_req,
   input  logic                  req_critical,
   input  logic [TASK_W-1:0]     req_current_task,
   input  logic                  req_current_valid,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [TASK_W-1:0]     rsp_next_task,
   output logic                  rsp_dispatch_needed,
   output logic                  rsp_skipped,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata
);

   localparam int TW         = (NUM_TASKS > 1) ? $clog2(NUM_TASKS) : 1;
   localparam int LW         = (PRIO_LEVELS > 1) ? $clog2(PRIO_LEVELS) : 1;
   localparam int IDLE_LEVEL = PRIO_LEVELS - 1;
   localparam int CMPW       = (TW > TASK_W) ? TW : TASK_W;
   localparam logic [LW-1:0] IDLE_LVL = LW'(IDLE_LEVEL);

   // Tables
   logic [TW-1:0] next_link_ff   [NUM_TASKS];
   logic [TW-1:0] prev_link_ff   [NUM_TASKS];
   logic [LW-1:0] task_level_ff  [NUM_TASKS];
   logic [TW-1:0] level_first_ff [PRIO_LEVELS];
   logic [TW-1:0] level_last_ff  [PRIO_LEVELS];

   // Registered read data
   logic [TW-1:0] nl_rd_ff, pl_rd_ff, lf_rd_ff, ll_rd_ff;
   logic [LW-1:0] tl_rd_ff;

   // Read and write ports
   logic          nl_re, pl_re, tl_re, lf_re, ll_re;
   logic [TW-1:0] nl_ra, pl_ra, tl_ra;
   logic [LW-1:0] lf_ra, ll_ra;
   logic          nl_we, pl_we, tl_we, lf_we, ll_we;
   logic [TW-1:0] nl_wa, pl_wa, tl_wa, nl_wd, pl_wd, lf_wd, ll_wd;
   logic [LW-1:0] lf_wa, ll_wa, tl_wd;

   // Flags and register
   logic [PRIO_LEVELS-1:0] occ_ff, occ_in;
   logic [NUM_TASKS-1:0]   in_list_ff, in_list_in;
   logic [TW-1:0]          idle_ff;

   // Captured item
   logic [TW-1:0]     tid_ff;
   logic [LW-1:0]     lvl_ff;
   logic              empty_ff, sched_ff, crit_ff, curv_ff;
   logic [TASK_W-1:0] cur_ff;

   // Output register
   logic              rsp_valid_ff;
   logic [TASK_W-1:0] next_task_ff;
   logic              dispatch_ff, skipped_ff;

   // Request decode
   logic                   csr_wr, init_go;
   logic [TASK_W-1:0]      csr_val;
   logic [TW-1:0]          init_task, tid_req;
   logic [LW-1:0]          lvl_req, anchor_lvl;
   logic                   tid_ok, prio_ok;
   logic [PRIO_LEVELS-1:0] cand, cand_first;
   logic                   rem_head, rem_empties;

   assign csr_val   = pwdata[TASK_W-1:0];
   assign csr_wr    = psel & penable & pwrite & (paddr[CSR_INDEX_BIT] == REG_IDLE_TASK) &
                      (int'(csr_val) < NUM_TASKS);
   assign init_go   = csr_wr || (cmd.wr == WR_INIT);
   assign init_task = csr_wr ? TW'(csr_val) : idle_ff;
   assign prdata    = CSR_DATA_W'(idle_ff);

   assign tid_req = TW'(req_task_id);
   assign lvl_req = LW'(req_priority_req);
   assign tid_ok  = int'(req_task_id) < NUM_TASKS;
   assign prio_ok = int'(req_priority_req) < IDLE_LEVEL;

   assign status.ins_ok = (req_action == ACT_INSERT) && tid_ok && prio_ok &&
                          !in_list_ff[tid_req] && (tid_req != idle_ff);
   assign status.rem_ok = (req_action == ACT_REMOVE) && tid_ok &&
                          in_list_ff[tid_req] && (tid_req != idle_ff);
   assign status.out_busy = rsp_valid_ff && !rsp_ready;

   // Occupied levels strictly between the request level and the idle level
   always_comb begin
      for (int q = 0; q < PRIO_LEVELS; q++) begin
         cand[q] = occ_ff[q] && (q > int'(lvl_req)) && (q < IDLE_LEVEL);
      end
   end

   // Lowest of them, or the idle level when there is none
   assign cand_first = cand & (~cand + PRIO_LEVELS'(1));

   always_comb begin
      logic [LW-1:0] enc;
      enc = '0;
      for (int q = 0; q < PRIO_LEVELS; q++) begin
         enc = enc | (cand_first[q] ? LW'(q) : LW'(0));
      end
      if (occ_ff[lvl_req]) begin
         anchor_lvl = lvl_req;
      end else if (|cand) begin
         anchor_lvl = enc;
      end else begin
         anchor_lvl = IDLE_LVL;
      end
   end

   // Read addresses
   always_comb begin
      nl_re = 1'b0;
      pl_re = 1'b0;
      tl_re = 1'b0;
      lf_re = 1'b0;
      ll_re = 1'b0;
      nl_ra = tid_req;
      pl_ra = tid_req;
      tl_ra = tid_req;
      lf_ra = anchor_lvl;
      ll_ra = anchor_lvl;
      case (cmd.rd)
         RD_REQ: begin
            nl_re = 1'b1;
            pl_re = 1'b1;
            tl_re = 1'b1;
            lf_re = 1'b1;
            ll_re = 1'b1;
            if (req_action == ACT_SCHEDULE) begin
               nl_ra = idle_ff;
            end
         end
         RD_INS_ANCHOR: begin
            // successor of the anchor task
            nl_re = 1'b1;
            nl_ra = ll_rd_ff;
         end
         RD_REM_LEVEL: begin
            lf_re = 1'b1;
            ll_re = 1'b1;
            tl_re = 1'b1;
            lf_ra = tl_rd_ff;
            ll_ra = tl_rd_ff;
            tl_ra = nl_rd_ff;
         end
         default: begin
         end
      endcase
   end

   assign rem_head    = (lf_rd_ff == tid_ff);
   assign rem_empties = rem_head && (tl_rd_ff != lvl_ff);

   // Writes
   always_comb begin
      nl_we = 1'b0;
      pl_we = 1'b0;
      tl_we = 1'b0;
      lf_we = 1'b0;
      ll_we = 1'b0;
      nl_wa = tid_ff;
      pl_wa = tid_ff;
      tl_wa = tid_ff;
      lf_wa = lvl_ff;
      ll_wa = lvl_ff;
      nl_wd = tid_ff;
      pl_wd = tid_ff;
      tl_wd = lvl_ff;
      lf_wd = tid_ff;
      ll_wd = tid_ff;
      occ_in     = occ_ff;
      in_list_in = in_list_ff;
      if (init_go) begin
         nl_we = 1'b1;
         pl_we = 1'b1;
         tl_we = 1'b1;
         lf_we = 1'b1;
         ll_we = 1'b1;
         nl_wa = init_task;
         nl_wd = init_task;
         pl_wa = init_task;
         pl_wd = init_task;
         tl_wa = init_task;
         tl_wd = IDLE_LVL;
         lf_wa = IDLE_LVL;
         lf_wd = init_task;
         ll_wa = IDLE_LVL;
         ll_wd = init_task;
         occ_in = '0;
         occ_in[IDLE_LEVEL] = 1'b1;
         in_list_in = '0;
         in_list_in[init_task] = 1'b1;
      end else begin
         case (cmd.wr)
            WR_INS_LINK: begin
               nl_we = 1'b1;
               nl_wd = nl_rd_ff;
               pl_we = 1'b1;
               pl_wa = nl_rd_ff;
               ll_we = 1'b1;
               tl_we = 1'b1;
               lf_we = empty_ff;
               occ_in[lvl_ff]     = 1'b1;
               in_list_in[tid_ff] = 1'b1;
            end
            WR_INS_CLOSE: begin
               // anchor still sits in the level-last read data
               nl_we = 1'b1;
               nl_wa = ll_rd_ff;
               pl_we = 1'b1;
               pl_wd = ll_rd_ff;
            end
            WR_REM_LINK: begin
               pl_we = 1'b1;
               pl_wa = nl_rd_ff;
               pl_wd = pl_rd_ff;
               nl_we = 1'b1;
               nl_wa = pl_rd_ff;
               nl_wd = nl_rd_ff;
               in_list_in[tid_ff] = 1'b0;
               if (rem_head) begin
                  if (rem_empties) begin
                     occ_in[lvl_ff] = 1'b0;
                  end else begin
                     lf_we = 1'b1;
                     lf_wd = nl_rd_ff;
                  end
               end else if (ll_rd_ff == tid_ff) begin
                  ll_we = 1'b1;
                  ll_wd = pl_rd_ff;
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (nl_we) begin
         next_link_ff[nl_wa] <= nl_wd;
      end
      if (nl_re) begin
         nl_rd_ff <= next_link_ff[nl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (pl_we) begin
         prev_link_ff[pl_wa] <= pl_wd;
      end
      if (pl_re) begin
         pl_rd_ff <= prev_link_ff[pl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (tl_we) begin
         task_level_ff[tl_wa] <= tl_wd;
      end
      if (tl_re) begin
         tl_rd_ff <= task_level_ff[tl_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (lf_we) begin
         level_first_ff[lf_wa] <= lf_wd;
      end
      if (lf_re) begin
         lf_rd_ff <= level_first_ff[lf_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (ll_we) begin
         level_last_ff[ll_wa] <= ll_wd;
      end
      if (ll_re) begin
         ll_rd_ff <= level_last_ff[ll_ra];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idle_ff    <= '0;
         occ_ff     <= PRIO_LEVELS'(1) << IDLE_LEVEL;
         in_list_ff <= NUM_TASKS'(1);
      end else begin
         if (csr_wr) begin
            idle_ff <= TW'(csr_val);
         end
         occ_ff     <= occ_in;
         in_list_ff <= in_list_in;
      end
   end

   // Item capture; the level is replaced by the task's own level on remove
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         tid_ff   <= tid_req;
         empty_ff <= !occ_ff[lvl_req];
         sched_ff <= (req_action == ACT_SCHEDULE);
         crit_ff  <= req_critical;
         cur_ff   <= req_current_task;
         curv_ff  <= req_current_valid;
      end
      if (cmd.capture) begin
         lvl_ff <= lvl_req;
      end else if (cmd.rd == RD_REM_LEVEL) begin
         lvl_ff <= tl_rd_ff;
      end
   end

   // Output register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.out_load) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         next_task_ff <= '0;
         dispatch_ff  <= 1'b0;
         skipped_ff   <= 1'b0;
         if (sched_ff) begin
            if (crit_ff) begin
               skipped_ff <= 1'b1;
            end else begin
               next_task_ff <= TASK_W'(nl_rd_ff);
               dispatch_ff  <= !curv_ff || (CMPW'(nl_rd_ff) != CMPW'(cur_ff));
            end
         end
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_next_task       = next_task_ff;
   assign rsp_dispatch_needed = dispatch_ff;
   assign rsp_skipped         = skipped_ff;

endmodule

@@ design/priority_ready_list_scheduler.sv @@
// Hardware ready list for a small real-time kernel. Every ready task sits on
// one circular doubly linked list anchored at the idle task, grouped by
// priority level with the idle level on top; insert appends a task at the
// tail of its level, remove unlinks it, and schedule returns the idle task's
// successor with a dispatch flag. One request is in work at a time. After
// the accept an insert steps through the anchor read, link and close states,
// a remove through the level read and link states, and a schedule or an
// ignored request goes straight to the response state, where the response
// register loads; a response still waiting at the output holds the next item
// in its response state until that transfer. The steps follow from the link
// tables, each a memory with one write port and a registered read port, so
// that a link update is a chain of dependent reads and writes. After reset
// the block seeds the idle entries in its init state before taking requests.
// Writing idle_task (byte address 0) rebuilds the list around the new idle
// task at once; the block must be idle when it is written.
// Depends on prls_pkg, prls_if, prls_ctrl and prls_datapath.
module priority_ready_list_scheduler import prls_pkg::*; #(
   parameter int NUM_TASKS   = NUM_TASKS_DEF,
   parameter int PRIO_LEVELS = PRIO_LEVELS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   prls_req_if.sink              req_ch,
   prls_rsp_if.source            rsp_ch,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   prls_cmd_type    cmd;
   prls_status_type status;
   logic            ctl_ready;

   assign pready       = 1'b1;
   assign req_ch.ready = ctl_ready;

   prls_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (ctl_ready),
      .status    (status),
      .cmd       (cmd)
   );

   prls_datapath #(
      .NUM_TASKS   (NUM_TASKS),
      .PRIO_LEVELS (PRIO_LEVELS)
   ) u_datapath (
      .clock               (clock),
      .reset               (reset),
      .cmd                 (cmd),
      .status              (status),
      .req_action          (req_ch.action),
      .req_task_id         (req_ch.task_id),
      .req_priority_req    (req_ch.priority_req),
      .req_critical        (req_ch.critical),
      .req_current_task    (req_ch.current_task),
      .req_current_valid   (req_ch.current_valid),
      .rsp_valid           (rsp_ch.valid),
      .rsp_ready           (rsp_ch.ready),
      .rsp_next_task       (rsp_ch.next_task),
      .rsp_dispatch_needed (rsp_ch.dispatch_needed),
      .rsp_skipped         (rsp_ch.skipped),
      .psel                (psel),
      .penable             (penable),
      .pwrite              (pwrite),
      .paddr               (paddr),
      .pwdata              (pwdata),
      .prdata              (prdata)
   );

endmodule

@@ verif/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for priority_ready_list_scheduler: a queue-fed request driver,
// a stalling response sink and a ready-list predictor, with idle_task set over APB.
// Depends on prls_pkg, prls_if and the scheduler RTL.
module tb;
   import prls_pkg::*;

   localparam int NTASK  = NUM_TASKS_DEF;
   localparam int NLEVEL = PRIO_LEVELS_DEF;
   localparam logic [PRIO_W-1:0] IDLE_LEVEL = PRIO_W'(NLEVEL - 1);
   localparam logic [ACTION_W-1:0] ACT_SPARE = 2'd3;
   localparam int SPARE_REG_INDEX = 1;
   localparam logic [CSR_ADDR_W-1:0] IDLE_TASK_ADDR = CSR_ADDR_W'(REG_IDLE_TASK) << CSR_INDEX_BIT;
   localparam logic [CSR_ADDR_W-1:0] SPARE_REG_ADDR = CSR_ADDR_W'(SPARE_REG_INDEX) << CSR_INDEX_BIT;
   localparam int PHASES          = 8;
   localparam int ITEMS_PER_PHASE = 150;
   localparam int DRAIN_CYCLES    = 10;
   localparam int QUIET_LIMIT     = 5000;

   typedef struct packed {
      logic [ACTION_W-1:0] action;
      logic [TASK_W-1:0]   task_id;
      logic [PRIO_W-1:0]   priority_req;
      logic                critical;
      logic [TASK_W-1:0]   current_task;
      logic                current_valid;
   } sched_req_t;

   typedef struct packed {
      logic [TASK_W-1:0] next_task;
      logic              dispatch_needed;
      logic              skipped;
   } sched_pick_t;

   logic                  clock;
   logic                  reset;
   logic                  psel;
   logic                  penable;
   logic                  pwrite;
   logic [CSR_ADDR_W-1:0] paddr;
   logic [CSR_DATA_W-1:0] pwdata;
   logic [CSR_DATA_W-1:0] prdata;
   logic                  pready;

   prls_req_if req_ch();
   prls_rsp_if rsp_ch();

   priority_ready_list_scheduler DUT (
      .clock   (clock),
      .reset   (reset),
      .req_ch  (req_ch),
      .rsp_ch  (rsp_ch),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready)
   );

   // Predicted ready list
   logic [TASK_W-1:0] fwd_link   [NTASK];
   logic [TASK_W-1:0] back_link  [NTASK];
   logic [PRIO_W-1:0] level_of   [NTASK];
   logic [TASK_W-1:0] level_head [NLEVEL];
   logic [TASK_W-1:0] level_tail [NLEVEL];
   logic [NLEVEL-1:0] levels_busy;
   logic [NTASK-1:0]  on_list;
   logic [TASK_W-1:0] idle_id;

   // Membership as seen by the stimulus generator, ahead of acceptance
   logic [NTASK-1:0]  gen_listed;
   logic [PRIO_W-1:0] gen_level [NTASK];
   logic [TASK_W-1:0] gen_idle;

   sched_req_t  queued_requests [$];
   sched_pick_t predicted_picks [$];

   logic        req_xfer;
   logic        req_calm;
   logic        rsp_calm;
   int unsigned faults;
   int unsigned quiet_cycles;
   int unsigned requests_taken;
   int unsigned picks_made;
   int unsigned dispatches;
   int unsigned suppressed;

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic void seed_ready_list(input logic [TASK_W-1:0] idle);
      for (int i = 0; i < NTASK; i++) begin
         fwd_link[i]  = '0;
         back_link[i] = '0;
         level_of[i]  = '0;
      end
      for (int l = 0; l < NLEVEL; l++) begin
         level_head[l] = '0;
         level_tail[l] = '0;
      end
      idle_id                = idle;
      fwd_link[idle]         = idle;
      back_link[idle]        = idle;
      level_of[idle]         = IDLE_LEVEL;
      level_head[IDLE_LEVEL] = idle;
      level_tail[IDLE_LEVEL] = idle;
      on_list                = '0;
      on_list[idle]          = 1'b1;
      levels_busy            = '0;
      levels_busy[IDLE_LEVEL] = 1'b1;
   endfunction

   function automatic void link_in(input logic [TASK_W-1:0] t, input logic [PRIO_W-1:0] lv);
      logic [TASK_W-1:0] anchor;
      int                q;
      if (on_list[t] || t == idle_id || lv >= IDLE_LEVEL)
         return;
      if (levels_busy[lv]) begin
         anchor = level_tail[lv];
      end else begin
         // splice after the nearest occupied level above; idle level always counts
         q = int'(lv) + 1;
         while (q < int'(IDLE_LEVEL) && !levels_busy[q])
            q++;
         anchor          = level_tail[q];
         level_head[lv]  = t;
         levels_busy[lv] = 1'b1;
      end
      fwd_link[t]            = fwd_link[anchor];
      back_link[fwd_link[t]] = t;
      fwd_link[anchor]       = t;
      back_link[t]           = anchor;
      level_tail[lv]         = t;
      level_of[t]            = lv;
      on_list[t]             = 1'b1;
   endfunction

   function automatic void link_out(input logic [TASK_W-1:0] t);
      logic [PRIO_W-1:0] lv;
      logic [TASK_W-1:0] nx;
      logic [TASK_W-1:0] pv;
      if (!on_list[t] || t == idle_id)
         return;
      lv = level_of[t];
      nx = fwd_link[t];
      pv = back_link[t];
      if (level_head[lv] == t) begin
         if (level_of[nx] != lv) begin
            level_head[lv]  = '0;
            level_tail[lv]  = '0;
            levels_busy[lv] = 1'b0;
         end else begin
            level_head[lv] = nx;
         end
      end else if (level_tail[lv] == t) begin
         level_tail[lv] = pv;
      end
      back_link[nx] = pv;
      fwd_link[pv]  = nx;
      on_list[t]    = 1'b0;
   endfunction

   function automatic sched_pick_t predict_pick(input sched_req_t r);
      sched_pick_t p;
      p = '0;
      case (r.action)
         ACT_INSERT: link_in(r.task_id, r.priority_req);
         ACT_REMOVE: link_out(r.task_id);
         ACT_SCHEDULE: begin
            if (r.critical) begin
               p.skipped = 1'b1;
            end else begin
               p.next_task       = fwd_link[idle_id];
               p.dispatch_needed = !r.current_valid || fwd_link[idle_id] != r.current_task;
            end
         end
         default: ;
      endcase
      return p;
   endfunction

   function automatic int unsigned draw_pause(input logic calm);
      int unsigned roll;
      if (calm)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 55)
         return 0;
      if (roll < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 30);
   endfunction

   function automatic void stage(input int act, input int tid, input int lv, input int crit,
                                 input int cur, input int curv);
      sched_req_t r;
      r.action        = ACTION_W'(act);
      r.task_id       = TASK_W'(tid);
      r.priority_req  = PRIO_W'(lv);
      r.critical      = 1'(crit);
      r.current_task  = TASK_W'(cur);
      r.current_valid = 1'(curv);
      queued_requests.push_back(r);
   endfunction

   // Mostly well-formed traffic: inserts of absent tasks, removes of present ones,
   // schedules naming a likely winner; the rest is left fully random.
   function automatic sched_req_t build_request();
      sched_req_t        r;
      logic [31:0]       raw;
      logic [TASK_W-1:0] pool [$];
      logic [PRIO_W-1:0] top;
      logic              any;
      int unsigned       roll;
      raw  = $urandom;
      r    = raw[$bits(sched_req_t)-1:0];
      roll = $urandom_range(0, 99);
      if (roll < 40) begin
         r.action = ACT_INSERT;
         if ($urandom_range(0, 9) != 0) begin
            for (int i = 0; i < NTASK; i++)
               if (!gen_listed[i] && TASK_W'(i) != gen_idle)
                  pool.push_back(TASK_W'(i));
            if (pool.size() != 0)
               r.task_id = pool[$urandom_range(0, pool.size() - 1)];
            r.priority_req = PRIO_W'($urandom_range(0, NLEVEL - 2));
         end
      end else if (roll < 70) begin
         r.action = ACT_REMOVE;
         if ($urandom_range(0, 9) != 0) begin
            for (int i = 0; i < NTASK; i++)
               if (gen_listed[i] && TASK_W'(i) != gen_idle)
                  pool.push_back(TASK_W'(i));
            if (pool.size() != 0)
               r.task_id = pool[$urandom_range(0, pool.size() - 1)];
         end
      end else if (roll < 94) begin
         r.action        = ACT_SCHEDULE;
         r.critical      = ($urandom_range(0, 6) == 0);
         r.current_valid = ($urandom_range(0, 7) != 0);
         if ($urandom_range(0, 9) < 6) begin
            top = '0;
            any = 1'b0;
            for (int i = 0; i < NTASK; i++)
               if (gen_listed[i] && TASK_W'(i) != gen_idle && (!any || gen_level[i] > top)) begin
                  top = gen_level[i];
                  any = 1'b1;
               end
            for (int i = 0; i < NTASK; i++)
               if (any && gen_listed[i] && TASK_W'(i) != gen_idle && gen_level[i] == top)
                  pool.push_back(TASK_W'(i));
            r.current_task = any ? pool[$urandom_range(0, pool.size() - 1)] : gen_idle;
         end
      end
      if (r.action == ACT_INSERT && !gen_listed[r.task_id] && r.task_id != gen_idle
          && r.priority_req < IDLE_LEVEL) begin
         gen_listed[r.task_id] = 1'b1;
         gen_level[r.task_id]  = r.priority_req;
      end else if (r.action == ACT_REMOVE && r.task_id != gen_idle) begin
         gen_listed[r.task_id] = 1'b0;
      end
      return r;
   endfunction

   function automatic void note_fault(input string msg);
      faults++;
      if (faults <= 10)
         $display("mismatch at %0t: %s", $realtime, msg);
   endfunction

   task automatic csr_access(input logic wr, input logic [CSR_ADDR_W-1:0] addr,
                             input logic [CSR_DATA_W-1:0] data);
      @(negedge clock);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= wr;
      paddr   <= addr;
      pwdata  <= data;
      @(negedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      @(negedge clock);
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
   endtask

   task automatic wait_until_drained();
      do @(posedge clock);
      while (queued_requests.size() != 0 || req_ch.valid || predicted_picks.size() != 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // Request driver
   always @(negedge clock) begin
      sched_req_t  r;
      int unsigned gap_left;
      if (reset) begin
         req_ch.valid <= 1'b0;
         gap_left = 0;
      end else if (!req_ch.valid || req_xfer) begin
         if (gap_left > 0) begin
            req_ch.valid <= 1'b0;
            gap_left--;
         end else if (queued_requests.size() != 0) begin
            r = queued_requests.pop_front();
            req_ch.action        <= r.action;
            req_ch.task_id       <= r.task_id;
            req_ch.priority_req  <= r.priority_req;
            req_ch.critical      <= r.critical;
            req_ch.current_task  <= r.current_task;
            req_ch.current_valid <= r.current_valid;
            req_ch.valid         <= 1'b1;
            gap_left = draw_pause(req_calm);
         end else begin
            req_ch.valid <= 1'b0;
         end
      end
   end

   // Response sink with random back-pressure
   always @(negedge clock) begin
      int unsigned stall_left;
      if (reset) begin
         rsp_ch.ready <= 1'b0;
         stall_left = 0;
      end else if (stall_left > 0) begin
         rsp_ch.ready <= 1'b0;
         stall_left--;
      end else begin
         rsp_ch.ready <= 1'b1;
         stall_left = draw_pause(rsp_calm);
      end
   end

   // Monitor: predict on each request transfer, check each response transfer
   always @(posedge clock) begin
      sched_req_t  r;
      sched_pick_t got;
      sched_pick_t want;
      if (reset) begin
         seed_ready_list('0);
         predicted_picks.delete();
         req_xfer <= 1'b0;
      end else begin
         req_xfer <= req_ch.valid && req_ch.ready;
         if (rsp_ch.valid && rsp_ch.ready) begin
            got = '{rsp_ch.next_task, rsp_ch.dispatch_needed, rsp_ch.skipped};
            if (predicted_picks.size() == 0) begin
               note_fault($sformatf("unexpected response next=%0d dispatch=%0b skipped=%0b",
                                    got.next_task, got.dispatch_needed, got.skipped));
            end else begin
               want = predicted_picks.pop_front();
               if (got !== want)
                  note_fault($sformatf("next %0d/%0d dispatch %0b/%0b skipped %0b/%0b (exp/got)",
                                       want.next_task, got.next_task, want.dispatch_needed,
                                       got.dispatch_needed, want.skipped, got.skipped));
            end
         end
         if (req_ch.valid && req_ch.ready) begin
            r    = '{req_ch.action, req_ch.task_id, req_ch.priority_req, req_ch.critical,
                     req_ch.current_task, req_ch.current_valid};
            want = predict_pick(r);
            predicted_picks.push_back(want);
            requests_taken++;
            if (r.action == ACT_SCHEDULE && !r.critical)
               picks_made++;
            if (want.dispatch_needed)
               dispatches++;
            if (want.skipped)
               suppressed++;
         end
         if (psel && penable && pready) begin
            if (paddr[CSR_ADDR_W-1:CSR_INDEX_BIT] == REG_IDLE_TASK) begin
               if (pwrite)
                  seed_ready_list(pwdata[TASK_W-1:0]);
               else if (prdata !== CSR_DATA_W'(idle_id))
                  note_fault($sformatf("idle_task read %0d, expected %0d", prdata, idle_id));
            end
         end
      end
   end

   // Watchdog on cycles without any transfer
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)
          || (psel && penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      int unsigned       idle_pick;
      logic [CSR_DATA_W-1:0] wdata;
      reset                = 1'b1;
      psel                 = 1'b0;
      penable              = 1'b0;
      pwrite               = 1'b0;
      paddr                = '0;
      pwdata               = '0;
      req_ch.valid         = 1'b0;
      req_ch.action        = ACT_INSERT;
      req_ch.task_id       = '0;
      req_ch.priority_req  = '0;
      req_ch.critical      = 1'b0;
      req_ch.current_task  = '0;
      req_ch.current_valid = 1'b0;
      rsp_ch.ready         = 1'b0;
      req_calm             = 1'b0;
      rsp_calm             = 1'b0;
      faults               = 0;
      requests_taken       = 0;
      picks_made           = 0;
      dispatches           = 0;
      suppressed           = 0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part around the reset idle task 0
      stage(ACT_SCHEDULE, 0, 0, 0, 0, 1);     // list holds only idle
      stage(ACT_SCHEDULE, 31, 15, 0, 31, 0);  // nothing running
      stage(ACT_INSERT, 31, 14, 0, 0, 0);     // empty top level: splice after idle
      stage(ACT_INSERT, 1, 0, 1, 31, 1);      // empty bottom level: splice after level 14
      stage(ACT_INSERT, 2, 0, 0, 0, 0);       // tail of an occupied level
      stage(ACT_INSERT, 3, 7, 0, 0, 0);       // empty level between two occupied ones
      stage(ACT_INSERT, 4, 15, 0, 0, 0);      // idle level: dropped
      stage(ACT_INSERT, 0, 3, 0, 0, 0);       // idle task itself: dropped
      stage(ACT_INSERT, 1, 5, 0, 0, 0);       // already listed: dropped
      stage(ACT_INSERT, 5, 14, 0, 0, 0);
      stage(ACT_SCHEDULE, 0, 0, 0, 31, 1);    // winner already running
      stage(ACT_SCHEDULE, 0, 0, 1, 0, 1);     // critical section
      stage(ACT_REMOVE, 6, 0, 0, 0, 0);       // not listed
      stage(ACT_REMOVE, 0, 0, 0, 0, 0);       // idle task
      stage(ACT_REMOVE, 5, 0, 0, 0, 0);       // tail of a level
      stage(ACT_REMOVE, 31, 0, 0, 0, 0);      // last of a level: level empties
      stage(ACT_SCHEDULE, 0, 0, 0, 3, 1);
      stage(ACT_REMOVE, 1, 0, 0, 0, 0);       // head with a follower on the level
      stage(ACT_REMOVE, 2, 0, 0, 0, 0);
      stage(ACT_SPARE, 31, 15, 1, 31, 1);
      stage(ACT_INSERT, 31, 8, 0, 0, 0);
      stage(ACT_INSERT, 30, 9, 0, 0, 0);
      stage(ACT_INSERT, 16, 8, 0, 0, 0);
      stage(ACT_REMOVE, 3, 0, 0, 0, 0);       // end of the list, before idle: level empties
      stage(ACT_SCHEDULE, 0, 0, 0, 30, 0);
      wait_until_drained();

      for (int p = 0; p < PHASES; p++) begin
         case (p)
            0:       idle_pick = NTASK - 1;
            1:       idle_pick = 0;
            default: idle_pick = $urandom_range(0, NTASK - 1);
         endcase
         if (p == 3)
            csr_access(1'b1, SPARE_REG_ADDR, $urandom);   // unmapped register
         wdata                = $urandom;
         wdata[TASK_W-1:0]    = TASK_W'(idle_pick);
         csr_access(1'b1, IDLE_TASK_ADDR, wdata);
         csr_access(1'b0, IDLE_TASK_ADDR, '0);
         gen_idle             = TASK_W'(idle_pick);
         gen_listed           = '0;
         gen_listed[gen_idle] = 1'b1;
         req_calm             = (p % 3 == 1);
         rsp_calm             = (p % 4 == 2);
         repeat (ITEMS_PER_PHASE)
            queued_requests.push_back(build_request());
         wait_until_drained();
      end

      $display("covered %0d requests over %0d idle-task settings: %0d schedules picked a task,",
               requests_taken, PHASES + 1, picks_made);
      $display("  %0d flagged a dispatch, %0d were held off by a critical section",
               dispatches, suppressed);
      if (faults == 0 && predicted_picks.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
